// ===== rtl/stok_pkg.sv =====
// types, constants and helper functions shared by the tokenizer modules
`timescale 1ns / 1ps
`default_nettype none
package stok_pkg;

  localparam int PosBits = 24;
  localparam int LineBits = 24;
  localparam int KwMaxLen = 7;
  localparam int WlenBits = $clog2(KwMaxLen + 2);
  localparam int MaxRes = 3;
  localparam int FifoDepth = 4;
  localparam int FifoAw = $clog2(FifoDepth);

  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};
  localparam logic [LineBits-1:0] LineTop = {LineBits{1'b1}};

  localparam logic [5:0] KindEnd = 6'd0;
  localparam logic [5:0] KindError = 6'd1;
  localparam logic [5:0] KindInt = 6'd2;
  localparam logic [5:0] KindFloat = 6'd3;
  localparam logic [5:0] KindBinary = 6'd4;
  localparam logic [5:0] KindString = 6'd5;
  localparam logic [5:0] KindIdent = 6'd6;
  localparam logic [5:0] KindShl = 6'd47;
  localparam logic [5:0] KindShr = 6'd50;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrUnknown = 2'd1;
  localparam logic [1:0] ErrString = 2'd2;
  localparam logic [1:0] ErrDepth = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE, M_PUNCT, M_LINECOM, M_BLKSTART, M_BLK, M_IDENT,
    M_ZERO, M_INT, M_DOT, M_FRAC, M_BIN, M_STR
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0] token_kind;
    logic [1:0] error_kind;
    logic [23:0] line_number;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic last_of_run;
  } out_item_t;

  // one classified event between front and back
  typedef struct packed {
    logic [1:0] count;
    out_item_t r0;
    out_item_t r1;
    out_item_t r2;
  } burst_t;

  typedef logic [KwMaxLen-1:0][7:0] word_t;

  function automatic logic digit_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic alpha_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
  endfunction

  function automatic logic [5:0] kind_single(input logic [7:0] c);
    case (c)
      8'h28: return 6'd26;  8'h29: return 6'd27;  8'h7b: return 6'd28;
      8'h7d: return 6'd29;  8'h3d: return 6'd31;  8'h21: return 6'd33;
      8'h2b: return 6'd35;  8'h2d: return 6'd37;  8'h2a: return 6'd39;
      8'h2f: return 6'd41;  8'h7c: return 6'd42;  8'h26: return 6'd43;
      8'h23: return 6'd44;  8'h3b: return 6'd45;  8'h3c: return 6'd48;
      8'h3e: return 6'd51;  8'h5b: return 6'd52;  8'h5d: return 6'd53;
      8'h3a: return 6'd55;  8'h25: return 6'd56;  8'h5e: return 6'd57;
      8'h7e: return 6'd58;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] kind_with_eq(input logic [7:0] c);
    case (c)
      8'h3d: return 6'd30;  8'h21: return 6'd32;  8'h2b: return 6'd34;
      8'h2d: return 6'd36;  8'h2a: return 6'd38;  8'h2f: return 6'd40;
      8'h3c: return 6'd46;  8'h3e: return 6'd49;  8'h3a: return 6'd54;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic wmatch(input word_t w, input logic [WlenBits-1:0] n,
                                  input logic [55:0] txt, input int len);
    logic ok;
    ok = (n == WlenBits'(len));
    for (int i = 0; i < 7; i++) begin
      if (i < len && w[i] != txt[55-8*i -: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [5:0] word_kind(input word_t w, input logic [WlenBits-1:0] n);
    if (wmatch(w, n, "if     ", 2)) return 6'd7;
    if (wmatch(w, n, "int    ", 3)) return 6'd8;
    if (wmatch(w, n, "else   ", 4)) return 6'd9;
    if (wmatch(w, n, "elif   ", 4)) return 6'd10;
    if (wmatch(w, n, "string ", 6)) return 6'd11;
    if (wmatch(w, n, "boolean", 7)) return 6'd12;
    if (wmatch(w, n, "break  ", 5)) return 6'd13;
    if (wmatch(w, n, "float  ", 5)) return 6'd14;
    if (wmatch(w, n, "for    ", 3)) return 6'd15;
    if (wmatch(w, n, "func   ", 4)) return 6'd16;
    if (wmatch(w, n, "false  ", 5)) return 6'd17;
    if (wmatch(w, n, "while  ", 5)) return 6'd18;
    if (wmatch(w, n, "return ", 6)) return 6'd19;
    if (wmatch(w, n, "char   ", 4)) return 6'd20;
    if (wmatch(w, n, "cast   ", 4)) return 6'd21;
    if (wmatch(w, n, "and    ", 3)) return 6'd22;
    if (wmatch(w, n, "or     ", 2)) return 6'd23;
    if (wmatch(w, n, "true   ", 4)) return 6'd24;
    if (wmatch(w, n, "print  ", 5)) return 6'd25;
    return KindIdent;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/stok_front.sv =====
// scanner: takes source bytes and classifies them into bursts of tokens
`timescale 1ns / 1ps
`default_nettype none
module stok_front
  import stok_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] max_depth,
  input  wire logic       take,
  input  wire in_item_t   item,
  output burst_t          burst
);

  scan_mode_t mode, mode_next;
  logic [7:0] pend, pend_next;
  logic [8:0] depth, depth_next;
  logic [LineBits-1:0] line, line_next;
  logic [PosBits-1:0] offs, offs_next;
  logic [PosBits-1:0] tstart, tstart_next;
  word_t word, word_next;
  logic [WlenBits-1:0] wlen, wlen_next;
  logic halted, halted_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pend <= '0;
      depth <= '0;
      line <= LineBits'(1);
      offs <= '0;
      tstart <= '0;
      wlen <= '0;
      halted <= 1'b0;
    end else if (take) begin
      mode <= mode_next;
      pend <= pend_next;
      depth <= depth_next;
      line <= line_next;
      offs <= offs_next;
      tstart <= tstart_next;
      wlen <= wlen_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) word <= word_next;
  end

  always_comb begin
    logic [7:0] b;
    logic [PosBits-1:0] sat, dot;
    logic [1:0] n;
    out_item_t [2:0] r;
    logic go_idle;
    b = item.source_byte;
    sat = (offs < PosMax) ? offs + PosBits'(1) : PosMax;
    dot = (offs != '0) ? offs - PosBits'(1) : '0;
    mode_next = mode;
    pend_next = pend;
    depth_next = depth;
    line_next = line;
    offs_next = offs;
    tstart_next = tstart;
    word_next = word;
    wlen_next = wlen;
    halted_next = halted;
    n = 2'd0;
    r = '0;
    go_idle = 1'b0;

    if (item.end_of_source) begin
      if (!halted) begin
        case (mode)
          M_PUNCT: begin
            r[0] = '{kind_single(pend), ErrNone, line_next, tstart, 24'(offs - tstart), 1'b0};
            n = 2'd1;
          end
          M_BLK: begin
            if (pend == 8'h0a && line < LineTop) line_next = line + LineBits'(1);
            if (depth > {1'b0, max_depth}) begin
              r[0] = '{KindError, ErrDepth, line_next, tstart, 24'd0, 1'b0};
              n = 2'd1;
            end
          end
          M_IDENT: begin
            r[0] = '{word_kind(word, wlen), ErrNone, line, tstart,
                     24'(offs - tstart), 1'b0};
            n = 2'd1;
          end
          M_ZERO, M_INT: begin
            r[0] = '{KindInt, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
            n = 2'd1;
          end
          M_DOT: begin
            r[0] = '{KindInt, ErrNone, line, tstart,
                     (dot >= tstart) ? 24'(dot - tstart) : 24'd0, 1'b0};
            r[1] = '{KindError, ErrUnknown, line, dot, 24'd0, 1'b0};
            n = 2'd2;
          end
          M_FRAC: begin
            r[0] = '{KindFloat, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
            n = 2'd1;
          end
          M_BIN: begin
            r[0] = '{KindBinary, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
            n = 2'd1;
          end
          M_STR: begin
            r[0] = '{KindError, ErrString, line, tstart, 24'd0, 1'b0};
            n = 2'd1;
          end
          default: ;
        endcase
      end
      r[n] = '{KindEnd, ErrNone, line_next, offs, 24'd0, 1'b0};
      n = n + 2'd1;
      mode_next = M_IDLE;
      pend_next = '0;
      depth_next = '0;
      line_next = LineBits'(1);
      offs_next = '0;
      tstart_next = '0;
      wlen_next = '0;
      halted_next = 1'b0;
    end else begin
      offs_next = sat;
      if (!halted) begin
        case (mode)
          M_PUNCT: begin
            if (pend == 8'h2f && b == 8'h2f) mode_next = M_LINECOM;
            else if (pend == 8'h3c && b == 8'h2f) begin
              depth_next = 9'd1;
              mode_next = M_BLKSTART;
            end else if (b == 8'h3d && kind_with_eq(pend) != 6'd0) begin
              r[0] = '{kind_with_eq(pend), ErrNone, line, tstart, 24'(sat - tstart), 1'b0};
              n = 2'd1;
              mode_next = M_IDLE;
            end else if (b == pend && (pend == 8'h3c || pend == 8'h3e)) begin
              r[0] = '{(pend == 8'h3c) ? KindShl : KindShr, ErrNone, line, tstart,
                       24'(sat - tstart), 1'b0};
              n = 2'd1;
              mode_next = M_IDLE;
            end else begin
              r[0] = '{kind_single(pend), ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
              n = 2'd1;
              go_idle = 1'b1;
            end
          end
          M_LINECOM: if (b == 8'h0a) go_idle = 1'b1;
          M_BLKSTART: begin
            pend_next = b;
            mode_next = M_BLK;
          end
          M_BLK: begin
            if (pend == 8'h2f && b == 8'h3e) depth_next = depth - 9'd1;
            else if (pend == 8'h3c && b == 8'h2f) depth_next = depth + 9'd1;
            else if (pend == 8'h0a && line < LineTop) line_next = line + LineBits'(1);
            if (depth_next > {1'b0, max_depth}) begin
              r[0] = '{KindError, ErrDepth, line_next, tstart, 24'd0, 1'b0};
              n = 2'd1;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end else if (depth_next == '0) mode_next = M_IDLE;
            else pend_next = b;
          end
          M_IDENT: begin
            if (alpha_char(b) || digit_char(b)) begin
              if (wlen < WlenBits'(KwMaxLen)) word_next[wlen[WlenBits-2:0]] = b;
              if (wlen <= WlenBits'(KwMaxLen)) wlen_next = wlen + WlenBits'(1);
            end else begin
              r[0] = '{word_kind(word, wlen), ErrNone, line, tstart,
                       24'(offs - tstart), 1'b0};
              n = 2'd1;
              go_idle = 1'b1;
            end
          end
          M_ZERO: begin
            if (b == 8'h62) mode_next = M_BIN;
            else if (digit_char(b)) mode_next = M_INT;
            else if (b == 8'h2e) mode_next = M_DOT;
            else begin
              r[0] = '{KindInt, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
              n = 2'd1;
              go_idle = 1'b1;
            end
          end
          M_INT: begin
            if (b == 8'h2e) mode_next = M_DOT;
            else if (!digit_char(b)) begin
              r[0] = '{KindInt, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
              n = 2'd1;
              go_idle = 1'b1;
            end
          end
          M_DOT: begin
            if (digit_char(b)) mode_next = M_FRAC;
            else begin
              r[0] = '{KindInt, ErrNone, line, tstart,
                       (dot >= tstart) ? 24'(dot - tstart) : 24'd0, 1'b0};
              r[1] = '{KindError, ErrUnknown, line, dot, 24'd0, 1'b0};
              n = 2'd2;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_FRAC: begin
            if (!digit_char(b)) begin
              r[0] = '{KindFloat, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
              n = 2'd1;
              go_idle = 1'b1;
            end
          end
          M_BIN: begin
            if (b != 8'h30 && b != 8'h31) begin
              r[0] = '{KindBinary, ErrNone, line, tstart, 24'(offs - tstart), 1'b0};
              n = 2'd1;
              go_idle = 1'b1;
            end
          end
          M_STR: begin
            if (b == 8'h22) begin
              r[0] = '{KindString, ErrNone, line, tstart, 24'(sat - tstart), 1'b0};
              n = 2'd1;
              mode_next = M_IDLE;
            end else if (b == 8'h0a && line < LineTop) line_next = line + LineBits'(1);
          end
          default: go_idle = 1'b1;
        endcase

        // byte seen from idle, possibly right after a flushed token
        if (go_idle) begin
          mode_next = M_IDLE;
          tstart_next = offs;
          if (b == 8'h20 || b == 8'h09 || b == 8'h0d) begin
          end else if (b == 8'h0a) begin
            if (line < LineTop) line_next = line + LineBits'(1);
          end else if (b == 8'h22) mode_next = M_STR;
          else if (b == 8'h30) mode_next = M_ZERO;
          else if (digit_char(b)) mode_next = M_INT;
          else if (alpha_char(b)) begin
            word_next[0] = b;
            wlen_next = WlenBits'(1);
            mode_next = M_IDENT;
          end else if (kind_with_eq(b) != 6'd0) begin
            pend_next = b;
            mode_next = M_PUNCT;
          end else if (kind_single(b) != 6'd0) begin
            r[n] = '{kind_single(b), ErrNone, line, offs, 24'(sat - offs), 1'b0};
            n = n + 2'd1;
          end else begin
            r[n] = '{KindError, ErrUnknown, line, offs, 24'd0, 1'b0};
            n = n + 2'd1;
            halted_next = 1'b1;
          end
        end
      end
    end
    if (n != 2'd0) r[n - 2'd1].last_of_run = 1'b1;
    burst.count = n;
    burst.r0 = r[0];
    burst.r1 = r[1];
    burst.r2 = r[2];
  end

endmodule
`default_nettype wire

// ===== rtl/stok_back.sv =====
// burst queue and result sequencer that hands out one token at a time
`timescale 1ns / 1ps
`default_nettype none
module stok_back
  import stok_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  wire burst_t    burst,
  output logic           full,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  burst_t mem [FifoDepth];
  logic [FifoAw:0] wptr, rptr;
  logic [1:0] sub;
  burst_t head;
  logic head_valid;
  logic adv;

  assign full = (wptr - rptr) == (FifoAw+1)'(FifoDepth);
  assign head_valid = wptr != rptr;
  assign head = mem[rptr[FifoAw-1:0]];
  assign empty = !head_valid;

  always_comb begin
    case (sub)
      2'd0: result = head.r0;
      2'd1: result = head.r1;
      default: result = head.r2;
    endcase
  end

  assign adv = pop && head_valid && (sub + 2'd1 == head.count);

  always_ff @(posedge clk) begin
    if (wr && !full && burst.count != 2'd0) mem[wptr[FifoAw-1:0]] <= burst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      sub <= '0;
    end else begin
      if (wr && !full && burst.count != 2'd0) wptr <= wptr + 1'b1;
      if (adv) begin
        rptr <= rptr + 1'b1;
        sub <= '0;
      end else if (pop && head_valid) begin
        sub <= sub + 2'd1;
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wptr - rptr) <= (FifoAw+1)'(FifoDepth)) else $error("queue overflow");
  a_sub_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> sub < head.count) else $error("sequencer past burst");
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (head_valid && result.last_of_run) |-> (sub + 2'd1 == head.count))
    else $error("last mark misplaced");
`endif

endmodule
`default_nettype wire

// ===== rtl/source_tokenizer_core.sv =====
// top level of the source tokenizer
`timescale 1ns / 1ps
`default_nettype none
// Streaming tokenizer: one source byte (or the end marker) is taken per cycle
// whenever full is low; the scanner classifies it in that same cycle and puts
// the zero to three tokens it produces, as one burst, into a queue that holds
// four such bursts (an item that makes no token takes no entry). When the queue
// is empty, the first token of an item is on the outputs the cycle after the item
// is taken. Tokens leave one per cycle while pop is high, through empty/pop, so an
// item making several tokens holds the output side until each of them is popped;
// full rises only when four bursts are waiting.
module source_tokenizer_core
  import stok_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  in_item,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      out_item,
  input  wire logic      cfg_we,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] max_depth;
  burst_t burst;
  logic take;

  always_ff @(posedge clk) begin
    if (rst) max_depth <= 8'd255;
    else if (cfg_we) max_depth <= cfg_data;
  end

  assign take = push && !full;

  stok_front u_front (
    .clk(clk), .rst(rst), .max_depth(max_depth), .take(take),
    .item(in_item), .burst(burst)
  );

  stok_back u_back (
    .clk(clk), .rst(rst), .wr(take), .burst(burst), .full(full),
    .empty(empty), .pop(pop), .result(out_item)
  );

endmodule
`default_nettype wire

// ===== verif/tokenizer_checker.sv =====
// token predictor and result checker for the source tokenizer testbench
`timescale 1ns / 1ps
module tokenizer_checker
  import stok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  in_item_t   in_item,
  input  logic       empty,
  input  logic       pop,
  input  out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         waiting
);

  localparam logic [5:0] PunctBase = 6'd26;
  localparam int NumKeywords = 19;

  // keyword and punctuator spellings in kind order
  string keywords [NumKeywords] = '{"if", "int", "else", "elif", "string", "boolean",
    "break", "float", "for", "func", "false", "while", "return", "char", "cast",
    "and", "or", "true", "print"};
  string puncts [33] = '{"(", ")", "{", "}", "==", "=", "!=", "!", "+=", "+", "-=",
    "-", "*=", "*", "/=", "/", "|", "&", "#", ";", "<=", "<<", "<", ">=", ">>", ">",
    "[", "]", ":=", ":", "%", "^", "~"};

  out_item_t token_q[$];

  logic [7:0] depth_limit;
  scan_mode_t mode;
  logic [7:0] pend;
  logic [8:0] cdepth;
  logic [23:0] line_cnt;
  logic [23:0] offs;
  logic [23:0] tstart;
  logic [7:0] word [KwMaxLen];
  int wlen;
  logic halted;
  int nres;

  function automatic logic [23:0] inc_sat(input logic [23:0] v);
    return (v == PosMax) ? v : v + 24'd1;
  endfunction

  function automatic logic digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    for (int i = 0; i < 33; i++)
      if (puncts[i].len() == 1 && puncts[i][0] == c) return PunctBase + 6'(i);
    return KindEnd;
  endfunction

  function automatic logic [5:0] eq_kind(input logic [7:0] c);
    for (int i = 0; i < 33; i++)
      if (puncts[i].len() == 2 && puncts[i][0] == c && puncts[i][1] == "=")
        return PunctBase + 6'(i);
    return KindEnd;
  endfunction

  function automatic logic [5:0] keyword_kind();
    logic same;
    for (int i = 0; i < NumKeywords; i++) begin
      if (keywords[i].len() == wlen && wlen <= KwMaxLen) begin
        same = 1'b1;
        for (int j = 0; j < wlen; j++) if (word[j] != keywords[i][j]) same = 1'b0;
        if (same) return KindIdent + 6'd1 + 6'(i);
      end
    end
    return KindIdent;
  endfunction

  task emit(input logic [5:0] kind, input logic [1:0] err, input logic [23:0] start,
            input logic [23:0] stop);
    out_item_t t;
    if (nres < MaxRes) begin
      t.token_kind = kind;
      t.error_kind = err;
      t.line_number = line_cnt;
      t.start_offset = start;
      t.token_length = (stop >= start) ? stop - start : 24'd0;
      t.last_of_run = 1'b0;
      token_q.insert(token_q.size(), t);
      nres++;
    end
  endtask

  task line_inc();
    if (line_cnt != LineTop) line_cnt = line_cnt + 24'd1;
  endtask

  task fail(input logic [1:0] err, input logic [23:0] at);
    emit(KindError, err, at, at);
    halted = 1'b1;
    mode = M_IDLE;
  endtask

  task clear_scan();
    mode = M_IDLE;
    pend = 8'd0;
    cdepth = 9'd0;
    line_cnt = 24'd1;
    offs = 24'd0;
    tstart = 24'd0;
    for (int i = 0; i < KwMaxLen; i++) word[i] = 8'd0;
    wlen = 0;
    halted = 1'b0;
  endtask

  task idle_byte(input logic [7:0] b);
    tstart = offs;
    if (b == " " || b == "\t" || b == "\r") return;
    if (b == "\n") begin
      line_inc();
      return;
    end
    if (b == "\"") mode = M_STR;
    else if (b == "0") mode = M_ZERO;
    else if (digit(b)) mode = M_INT;
    else if (letter(b)) begin
      word[0] = b;
      wlen = 1;
      mode = M_IDENT;
    end else if (eq_kind(b) != KindEnd) begin
      pend = b;
      mode = M_PUNCT;
    end else if (single_kind(b) != KindEnd) emit(single_kind(b), ErrNone, offs, inc_sat(offs));
    else fail(ErrUnknown, offs);
  endtask

  task comment_byte(input logic [7:0] p, input logic has_next, input logic [7:0] b);
    if (has_next && p == "/" && b == ">") cdepth = cdepth - 9'd1;
    else if (has_next && p == "<" && b == "/") cdepth = cdepth + 9'd1;
    else if (p == "\n") line_inc();
    if (cdepth > {1'b0, depth_limit}) fail(ErrDepth, tstart);
    else if (cdepth == 9'd0) mode = M_IDLE;
    else pend = b;
  endtask

  task close_token(input logic [5:0] kind, input logic [7:0] b);
    emit(kind, ErrNone, tstart, offs);
    mode = M_IDLE;
    idle_byte(b);
  endtask

  task dot_error();
    logic [23:0] dot;
    dot = (offs > 0) ? offs - 24'd1 : 24'd0;
    emit(KindInt, ErrNone, tstart, dot);
    fail(ErrUnknown, dot);
  endtask

  task scan(input logic [7:0] b);
    logic [7:0] c;
    c = pend;
    case (mode)
      M_PUNCT: begin
        if (c == "/" && b == "/") mode = M_LINECOM;
        else if (c == "<" && b == "/") begin
          cdepth = 9'd1;
          mode = M_BLKSTART;
        end else if (b == "=" && eq_kind(c) != KindEnd) begin
          emit(eq_kind(c), ErrNone, tstart, inc_sat(offs));
          mode = M_IDLE;
        end else if (b == c && (c == "<" || c == ">")) begin
          emit(c == "<" ? KindShl : KindShr, ErrNone, tstart, inc_sat(offs));
          mode = M_IDLE;
        end else close_token(single_kind(c), b);
      end
      M_LINECOM: if (b == "\n") begin
        mode = M_IDLE;
        idle_byte(b);
      end
      M_BLKSTART: begin
        pend = b;
        mode = M_BLK;
      end
      M_BLK: comment_byte(c, 1'b1, b);
      M_IDENT: begin
        if (letter(b) || digit(b)) begin
          if (wlen < KwMaxLen) word[wlen] = b;
          if (wlen <= KwMaxLen) wlen++;
        end else close_token(keyword_kind(), b);
      end
      M_ZERO: begin
        if (b == "b") mode = M_BIN;
        else if (digit(b)) mode = M_INT;
        else if (b == ".") mode = M_DOT;
        else close_token(KindInt, b);
      end
      M_INT: begin
        if (b == ".") mode = M_DOT;
        else if (!digit(b)) close_token(KindInt, b);
      end
      M_DOT: if (digit(b)) mode = M_FRAC; else dot_error();
      M_FRAC: if (!digit(b)) close_token(KindFloat, b);
      M_BIN: if (b != "0" && b != "1") close_token(KindBinary, b);
      M_STR: begin
        if (b == "\"") begin
          emit(KindString, ErrNone, tstart, inc_sat(offs));
          mode = M_IDLE;
        end else if (b == "\n") line_inc();
      end
      default: begin
        mode = M_IDLE;
        idle_byte(b);
      end
    endcase
  endtask

  task flush_end();
    case (mode)
      M_PUNCT: emit(single_kind(pend), ErrNone, tstart, offs);
      M_BLK: comment_byte(pend, 1'b0, 8'd0);
      M_IDENT: emit(keyword_kind(), ErrNone, tstart, offs);
      M_ZERO, M_INT: emit(KindInt, ErrNone, tstart, offs);
      M_DOT: dot_error();
      M_FRAC: emit(KindFloat, ErrNone, tstart, offs);
      M_BIN: emit(KindBinary, ErrNone, tstart, offs);
      M_STR: fail(ErrString, tstart);
      default: ;
    endcase
  endtask

  task predict_item(input in_item_t it);
    nres = 0;
    if (it.end_of_source) begin
      if (!halted) flush_end();
      emit(KindEnd, ErrNone, offs, offs);
      clear_scan();
    end else begin
      if (!halted) scan(it.source_byte);
      offs = inc_sat(offs);
    end
    if (nres > 0) token_q[token_q.size() - 1].last_of_run = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      depth_limit = 8'd255;
      clear_scan();
      token_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) depth_limit = cfg_data;
      if (push && !full) predict_item(in_item);
      if (pop && !empty) begin
        if (token_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token: kind %0d line %0d start %0d",
                                         out_item.token_kind, out_item.line_number,
                                         out_item.start_offset);
        end else begin
          want = token_q.pop_front();
          if (out_item.token_kind !== want.token_kind ||
              out_item.error_kind !== want.error_kind ||
              out_item.line_number !== want.line_number ||
              out_item.start_offset !== want.start_offset ||
              out_item.token_length !== want.token_length ||
              out_item.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("token mismatch: exp kind %0d err %0d line %0d start %0d len %0d last %0d",
                       want.token_kind, want.error_kind, want.line_number,
                       want.start_offset, want.token_length, want.last_of_run);
              $display("                got kind %0d err %0d line %0d start %0d len %0d last %0d",
                       out_item.token_kind, out_item.error_kind, out_item.line_number,
                       out_item.start_offset, out_item.token_length, out_item.last_of_run);
            end
          end
        end
      end
    end
    waiting = token_q.size();
  end

endmodule

// ===== verif/source_tokenizer_core_tb.sv =====
// stimulus and verdict for the source tokenizer
`timescale 1ns / 1ps
module source_tokenizer_core_tb;
  import stok_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_item_t in_item = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  int mismatches;
  int waiting;
  int sent = 0;
  logic quiet = 1'b0;

  string frags [] = '{"if", "int", "else", "elif", "string", "boolean", "break", "float",
    "for", "func", "false", "while", "return", "char", "cast", "and", "or", "true",
    "print", "iffy", "booleans", "_x9", "Zq", "0b101", "0b", "0", "07", "42", "3.14",
    "0.5", "9.", "\"hi\"", "\"a\nb\"", "()", "{}", "==", "=", "!=", "!", "+=", "+",
    "-=", "-", "*=", "*", "/=", "/", "|&#;", "<=", "<<", "<", ">=", ">>", ">", "[]",
    ":=", ":", "%^~", "// note\n", "</ x />", "</ </ a /> />", "<//>", "</\n/>", "\n",
    " ", "\t", "\r"};
  string broken [] = '{"</ open", "\"open", "</ </ x />", "5.", "a.b"};

  always #10 clk = ~clk;

  always @(posedge clk) pop <= quiet || ($urandom_range(99) >= 14);

  source_tokenizer_core DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  tokenizer_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .mismatches(mismatches), .waiting(waiting)
  );

  // push stays high after acceptance; the next caller either reloads or drops it
  task automatic send(input logic [7:0] b, input logic eos);
    if (!quiet) while ($urandom_range(99) < 14) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= '{source_byte: b, end_of_source: eos};
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  task automatic finish_source();
    send(8'($urandom_range(255)), 1'b1);
  endtask

  // only while the scanner is back at rest and every token has drained
  task automatic set_depth(input logic [7:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_source(input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 6) send(8'($urandom_range(255)), 1'b0);
      else begin
        send_text(frags[$urandom_range(frags.size() - 1)]);
        if ($urandom_range(3) != 0) send(" ", 1'b0);
      end
    end
    if ($urandom_range(7) == 0) send_text(broken[$urandom_range(broken.size() - 1)]);
    finish_source();
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: keyword, shifts, dot error, open string, bad byte, depth limit
    send_text("if<<=>>");
    finish_source();
    send_text("3.x");
    finish_source();
    send_text("\"ab");
    finish_source();
    send(8'h80, 1'b0);
    send(8'h00, 1'b1);
    send(8'hff, 1'b1);
    set_depth(8'd0);
    send_text("</a");
    finish_source();
    phase = 0;
    while (sent < 250) begin
      case (phase % 5)
        0: set_depth(8'd1);
        1: set_depth(8'd2);
        2: set_depth(8'd255);
        3: set_depth(8'd0);
        default: set_depth(8'($urandom_range(255)));
      endcase
      quiet = (phase == 2 || phase == 3);
      random_source($urandom_range(4, 12));
      phase++;
    end
    quiet = 1'b0;
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
